FILE: rtl/whc_pkg.sv
package whc_pkg;

  // Length of the captured part of an fmt chunk body
  localparam int CapLen = 18;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;

  localparam logic [15:0] FormatPcm = 16'd1;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_TRUNCATED = 4'd1,
    ST_NOT_RIFF  = 4'd2,
    ST_NOT_WAVE  = 4'd3,
    ST_FMT_SHORT = 4'd4,
    ST_CHANNELS  = 4'd5,
    ST_RATE      = 4'd6,
    ST_PCM_SHORT = 4'd7,
    ST_BITS      = 4'd8,
    ST_EXT_SHORT = 4'd9
  } status_e;

  // Register indexes of the write channel; the spare index is ignored
  typedef enum logic [1:0] {
    REG_CHANNELS = 2'd0,
    REG_RATE     = 2'd1,
    REG_BITS     = 2'd2,
    REG_SPARE    = 2'd3
  } cfg_reg_e;

  // Captured fmt body, byte 0 in the lowest slot
  typedef logic [CapLen-1:0][7:0] cap_t;

  // Verdict of the fmt chunk checks
  typedef struct packed {
    logic    fail;      // code is valid
    status_e code;
    logic    set_bits;  // bits per sample field may be latched
  } fmt_res_t;

endpackage

FILE: rtl/whc_fmt_check.sv
module whc_fmt_check
  import whc_pkg::*;
(
  input  cap_t        cap_i,
  input  logic [31:0] len_i,
  input  logic [15:0] exp_channels_i,
  input  logic [31:0] exp_rate_i,
  input  logic [15:0] exp_bits_i,
  output fmt_res_t    res_o
);

  logic [15:0] fmt_tag;
  logic [15:0] channels;
  logic [31:0] rate;
  logic [15:0] bits;
  logic [15:0] extra;
  logic        ext_too_short;

  assign fmt_tag  = {cap_i[1], cap_i[0]};
  assign channels = {cap_i[3], cap_i[2]};
  assign rate     = {cap_i[7], cap_i[6], cap_i[5], cap_i[4]};
  assign bits     = {cap_i[15], cap_i[14]};
  assign extra    = {cap_i[17], cap_i[16]};

  // extra bytes must fit within the declared chunk size
  assign ext_too_short = (extra != 16'd0) &&
                         ({1'b0, len_i} < (33'd18 + {17'd0, extra}));

  always_comb begin
    res_o = '{fail: 1'b0, code: ST_OK, set_bits: 1'b0};
    if (channels != exp_channels_i) begin
      res_o.fail = 1'b1;
      res_o.code = ST_CHANNELS;
    end else if (rate != exp_rate_i) begin
      res_o.fail = 1'b1;
      res_o.code = ST_RATE;
    end else if (fmt_tag == FormatPcm) begin
      if (len_i < 32'd16) begin
        res_o.fail = 1'b1;
        res_o.code = ST_PCM_SHORT;
      end else begin
        res_o.set_bits = 1'b1;
        if (bits != exp_bits_i) begin
          res_o.fail = 1'b1;
          res_o.code = ST_BITS;
        end
      end
    end else begin
      if (len_i < 32'd18) begin
        res_o.fail = 1'b1;
        res_o.code = ST_EXT_SHORT;
      end else begin
        res_o.set_bits = 1'b1;
        if (bits != exp_bits_i) begin
          res_o.fail = 1'b1;
          res_o.code = ST_BITS;
        end else if (ext_too_short) begin
          res_o.fail = 1'b1;
          res_o.code = ST_EXT_SHORT;
        end
      end
    end
  end

endmodule

FILE: rtl/wave_header_checker_core.sv
// Channel   | Dir | Payload                                        | Handshake
// ----------+-----+------------------------------------------------+--------------------------
// s_axis    | in  | tdata[7:0] file byte, tlast final byte of file | tvalid/tready
// m_axis    | out | tdata[199:0] status and captured header fields | tvalid/tready
// cfg       | in  | addr[1:0] register index, data[31:0] value     | cfg_valid_i/cfg_ready_o
//
// One file byte per cycle sustained while the result register has room; the parse step for a byte
// is a single register-to-register pass (byte insert, 32-bit counter, fmt compares).
// A status passes through the input register and then the result register before it shows on m_axis.
// rst_ni clears all parse state and loads channels 1, rate 44100, bits 16.
// Input stalls only while the result register is full and not being taken.
// cfg_ready_o is always high; writes are expected while the block is idle.
module wave_header_checker_core
  import whc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // byte stream in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // last_byte
  // status out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [3:0] status, [19:4] fmt_code, [35:20] channel_count,
  // [67:36] rate_hz, [99:68] byte_rate, [115:100] frame_align,
  // [131:116] sample_bits, [163:132] riff_length,
  // [195:164] first_chunk_length, [199:196] zero
  output logic [199:0] m_axis_tdata,
  // register writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_addr_i,
  input  logic [31:0]  cfg_data_i
);

  typedef enum logic [1:0] {
    PH_RIFF,  // 12-byte RIFF/WAVE header
    PH_HDR,   // 8-byte chunk header
    PH_FMT,   // fmt chunk body
    PH_SKIP   // any other chunk body
  } phase_e;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] exp_ch_q;
  logic [31:0] exp_rate_q;
  logic [15:0] exp_bits_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ch_q   <= 16'd1;
      exp_rate_q <= 32'd44100;
      exp_bits_q <= 16'd16;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_CHANNELS: exp_ch_q   <= cfg_data_i[15:0];
        REG_RATE:     exp_rate_q <= cfg_data_i;
        REG_BITS:     exp_bits_q <= cfg_data_i[15:0];
        default: ;  // unused index, ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       proc_fire;

  // a byte is parsed once the result register has room for its status
  assign proc_fire     = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // ---------------------------------------------------------------------
  // Parse state
  // ---------------------------------------------------------------------
  phase_e      phase_q, phase_d;
  logic [4:0]  idx_q, idx_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [31:0] skip_q, skip_d;
  cap_t        cap_q, cap_d;
  logic [31:0] riff_q, riff_d;
  logic [31:0] first_q, first_d;
  logic        seen_q, seen_d;
  logic        drop_q, drop_d;
  logic [15:0] bits_q, bits_d;

  logic        res_valid;
  logic [199:0] res_data;

  // byte placed at its little-endian slot of a 32-bit word
  logic [4:0]  shamt;
  logic [31:0] byte_word;
  logic [31:0] tag_new;
  logic [31:0] len_new;
  logic [31:0] padded;

  assign shamt     = {idx_q[1:0], 3'b000};
  assign byte_word = {24'd0, in_byte_q} << shamt;
  assign tag_new   = tag_q | byte_word;
  assign len_new   = len_q | byte_word;
  // pad to even; all ones wraps to zero
  assign padded    = (len_new + 32'd1) & ~32'd1;

  // fmt check: on an empty body it sees a cleared capture and the new size
  cap_t        chk_cap;
  logic [31:0] chk_len;
  fmt_res_t    chk_res;
  cap_t        cap_wr;

  always_comb begin
    cap_wr = cap_q;
    if (idx_q < 5'(CapLen)) begin
      cap_wr[idx_q] = in_byte_q;
    end
  end

  assign chk_cap = (phase_q == PH_FMT) ? cap_wr : '0;
  assign chk_len = (phase_q == PH_FMT) ? len_q  : len_new;

  whc_fmt_check u_fmt_check (
    .cap_i          (chk_cap),
    .len_i          (chk_len),
    .exp_channels_i (exp_ch_q),
    .exp_rate_i     (exp_rate_q),
    .exp_bits_i     (exp_bits_q),
    .res_o          (chk_res)
  );

  always_comb begin
    logic    st_valid;
    status_e st_code;
    logic    run_check;
    logic    clr;

    phase_d   = phase_q;
    idx_d     = idx_q;
    tag_d     = tag_q;
    len_d     = len_q;
    skip_d    = skip_q;
    cap_d     = cap_q;
    riff_d    = riff_q;
    first_d   = first_q;
    seen_d    = seen_q;
    drop_d    = drop_q;
    bits_d    = bits_q;
    st_valid  = 1'b0;
    st_code   = ST_OK;
    run_check = 1'b0;
    clr       = 1'b0;
    res_valid = 1'b0;
    res_data  = '0;

    if (proc_fire) begin
      if (drop_q) begin
        // discard the rest of a file that already reported
        clr = in_last_q;
      end else begin
        unique case (phase_q)
          PH_RIFF: begin
            if (idx_q < 5'd4) begin
              tag_d = tag_new;
            end else if (idx_q < 5'd8) begin
              riff_d = riff_q | byte_word;
            end else begin
              len_d = len_new;
            end
            idx_d = idx_q + 5'd1;
            if (idx_q == 5'd11) begin
              if (tag_d != TagRiff) begin
                riff_d   = '0;
                st_valid = 1'b1;
                st_code  = ST_NOT_RIFF;
              end else if (len_d != TagWave) begin
                st_valid = 1'b1;
                st_code  = ST_NOT_WAVE;
              end else begin
                phase_d = PH_HDR;
                idx_d   = '0;
                tag_d   = '0;
                len_d   = '0;
              end
            end
          end
          PH_HDR: begin
            if (idx_q < 5'd4) begin
              tag_d = tag_new;
            end else begin
              len_d = len_new;
            end
            idx_d = idx_q + 5'd1;
            if (idx_q == 5'd7) begin
              idx_d  = '0;
              skip_d = padded;
              if (!seen_q) begin
                first_d = len_new;
                seen_d  = 1'b1;
              end
              if (tag_q == TagFmt) begin
                if (len_new < 32'd14) begin
                  st_valid = 1'b1;
                  st_code  = ST_FMT_SHORT;
                end else begin
                  cap_d = '0;
                  if (padded == 32'd0) begin
                    run_check = 1'b1;
                  end else begin
                    phase_d = PH_FMT;
                  end
                end
              end else if (padded != 32'd0) begin
                phase_d = PH_SKIP;
              end
              if (phase_d == PH_HDR) begin
                tag_d = '0;
                len_d = '0;
              end
            end
          end
          PH_FMT: begin
            if (idx_q < 5'(CapLen)) begin
              cap_d = cap_wr;
              idx_d = idx_q + 5'd1;
            end
            skip_d = skip_q - 32'd1;
            if (skip_q == 32'd1) begin
              run_check = 1'b1;
              phase_d   = PH_HDR;
              idx_d     = '0;
              tag_d     = '0;
              len_d     = '0;
            end
          end
          PH_SKIP: begin
            skip_d = skip_q - 32'd1;
            if (skip_q == 32'd1) begin
              phase_d = PH_HDR;
              idx_d   = '0;
              tag_d   = '0;
              len_d   = '0;
            end
          end
          default: ;
        endcase

        if (run_check) begin
          if (chk_res.set_bits) begin
            bits_d = {chk_cap[15], chk_cap[14]};
          end
          if (chk_res.fail) begin
            st_valid = 1'b1;
            st_code  = chk_res.code;
          end
        end

        // end of file: clean only on a chunk boundary
        if (!st_valid && in_last_q) begin
          st_valid = 1'b1;
          st_code  = (phase_d == PH_HDR && idx_d == 5'd0) ? ST_OK : ST_TRUNCATED;
        end

        if (st_valid) begin
          res_valid = 1'b1;
          res_data  = {4'd0, first_d, riff_d, bits_d,
                       cap_d[13], cap_d[12],
                       cap_d[11], cap_d[10], cap_d[9], cap_d[8],
                       cap_d[7], cap_d[6], cap_d[5], cap_d[4],
                       cap_d[3], cap_d[2],
                       cap_d[1], cap_d[0],
                       st_code};
          if (in_last_q) begin
            clr = 1'b1;
          end else begin
            drop_d = 1'b1;
          end
        end
      end

      // fresh state for the next file
      if (clr) begin
        phase_d = PH_RIFF;
        idx_d   = '0;
        tag_d   = '0;
        len_d   = '0;
        skip_d  = '0;
        cap_d   = '0;
        riff_d  = '0;
        first_d = '0;
        seen_d  = 1'b0;
        drop_d  = 1'b0;
        bits_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      idx_q   <= '0;
      tag_q   <= '0;
      len_q   <= '0;
      skip_q  <= '0;
      cap_q   <= '0;
      riff_q  <= '0;
      first_q <= '0;
      seen_q  <= 1'b0;
      drop_q  <= 1'b0;
      bits_q  <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      skip_q  <= skip_d;
      cap_q   <= cap_d;
      riff_q  <= riff_d;
      first_q <= first_d;
      seen_q  <= seen_d;
      drop_q  <= drop_d;
      bits_q  <= bits_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic         out_valid_q;
  logic [199:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: rtl/whc_checker.sv
module whc_checker
  import whc_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [199:0] m_axis_tdata
);

  logic [3:0] st;
  assign st = m_axis_tdata[3:0];

  // a stalled status holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("status changed while stalled");

  // a bad RIFF id reports no RIFF size
  a_not_riff_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == ST_NOT_RIFF |-> m_axis_tdata[163:132] == 32'd0)
    else $error("riff length set on bad id");

  // PCM short only for PCM, extended short only for non-PCM
  a_pcm_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == ST_PCM_SHORT |-> m_axis_tdata[19:4] == FormatPcm)
    else $error("pcm short on non-pcm format");

  a_ext_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == ST_EXT_SHORT |-> m_axis_tdata[19:4] != FormatPcm)
    else $error("extended short on pcm format");

  // input side never stalls while the result register is free
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

endmodule

bind wave_header_checker_core whc_checker u_whc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import whc_pkg::*;

  localparam logic [31:0] TagData = 32'h6174_6164;
  // cycles without any handshake before the run is declared hung
  localparam int WatchdogLimit = 2000;
  // tail after the last expected report; a status passes the input and result registers of the DUT
  localparam int DrainCycles = 8;

  typedef enum logic [1:0] {
    PH_RIFF,
    PH_CHUNK_HDR,
    PH_FMT_BODY,
    PH_SKIP_BODY
  } parse_phase_e;

  // same layout as m_axis_tdata, lowest field last
  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] first_chunk_length;
    logic [31:0] riff_length;
    logic [15:0] sample_bits;
    logic [15:0] frame_align;
    logic [31:0] byte_rate;
    logic [31:0] rate_hz;
    logic [15:0] channel_count;
    logic [15:0] fmt_code;
    status_e     status;
  } status_report_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } file_byte_t;

  // clock and DUT ports
  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata  = '0;    // [7:0] data_byte
  logic         s_axis_tlast  = 1'b0;  // last_byte
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;          // status_report_t layout
  logic         cfg_valid_i   = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_addr_i    = '0;
  logic [31:0]  cfg_data_i    = '0;

  always #10 clk_i = ~clk_i;

  wave_header_checker_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  file_byte_t     pending_bytes[$];
  status_report_t expected_reports[$];
  logic [7:0]     file_bytes[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int bytes_queued   = 0;
  int files_queued   = 0;
  int quiet_cycles   = 0;

  // expected register contents
  logic [15:0] want_channels;
  logic [31:0] want_rate;
  logic [15:0] want_bits;

  // parser shadow state
  parse_phase_e m_phase;
  logic [4:0]   m_idx;
  logic [31:0]  m_tag;
  logic [31:0]  m_len;
  logic [31:0]  m_skip;
  logic [31:0]  m_riff_size;
  logic [31:0]  m_first_size;
  logic         m_seen_first;
  logic         m_dropping;
  logic [15:0]  m_bits;
  logic [7:0]   fmt_cap [CapLen];

  function automatic void clear_file();
    m_phase      = PH_RIFF;
    m_idx        = '0;
    m_tag        = '0;
    m_len        = '0;
    m_skip       = '0;
    m_riff_size  = '0;
    m_first_size = '0;
    m_seen_first = 1'b0;
    m_dropping   = 1'b0;
    m_bits       = '0;
    foreach (fmt_cap[i]) fmt_cap[i] = '0;
  endfunction

  function automatic logic [15:0] cap16(input int off);
    return {fmt_cap[off+1], fmt_cap[off]};
  endfunction

  function automatic logic [31:0] cap32(input int off);
    return {cap16(off + 2), cap16(off)};
  endfunction

  // fmt body checks; latches bits per sample once the size fits the format
  function automatic bit fmt_fails(output status_e code);
    logic [15:0] bits;
    logic [15:0] extra;
    bits  = cap16(14);
    extra = cap16(16);
    code  = ST_OK;
    if (cap16(2) != want_channels) begin
      code = ST_CHANNELS;
      return 1'b1;
    end
    if (cap32(4) != want_rate) begin
      code = ST_RATE;
      return 1'b1;
    end
    if (cap16(0) == FormatPcm) begin
      if (m_len < 32'd16) begin
        code = ST_PCM_SHORT;
        return 1'b1;
      end
      m_bits = bits;
      if (bits != want_bits) begin
        code = ST_BITS;
        return 1'b1;
      end
    end else begin
      if (m_len < 32'd18) begin
        code = ST_EXT_SHORT;
        return 1'b1;
      end
      m_bits = bits;
      if (bits != want_bits) begin
        code = ST_BITS;
        return 1'b1;
      end
      if (extra != 16'd0 && {1'b0, m_len} < 33'd18 + {17'd0, extra}) begin
        code = ST_EXT_SHORT;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // advance the shadow parser by one accepted byte
  task automatic parse_byte(input logic [7:0] b, input logic last);
    bit             fail;
    status_e        code;
    status_report_t rep;
    logic [31:0]    padded;
    fail = 1'b0;
    code = ST_OK;
    if (m_dropping) begin
      if (last) clear_file();
      return;
    end
    case (m_phase)
      PH_RIFF: begin
        if (m_idx < 5'd4) m_tag[{m_idx[1:0], 3'b000} +: 8] = b;
        else if (m_idx < 5'd8) m_riff_size[{m_idx[1:0], 3'b000} +: 8] = b;
        else m_len[{m_idx[1:0], 3'b000} +: 8] = b;
        m_idx++;
        if (m_idx >= 5'd12) begin
          if (m_tag != TagRiff) begin
            m_riff_size = '0;
            fail = 1'b1;
            code = ST_NOT_RIFF;
          end else if (m_len != TagWave) begin
            fail = 1'b1;
            code = ST_NOT_WAVE;
          end else begin
            m_phase = PH_CHUNK_HDR;
            m_idx   = '0;
            m_tag   = '0;
            m_len   = '0;
          end
        end
      end
      PH_CHUNK_HDR: begin
        if (m_idx < 5'd4) m_tag[{m_idx[1:0], 3'b000} +: 8] = b;
        else m_len[{m_idx[1:0], 3'b000} +: 8] = b;
        m_idx++;
        if (m_idx >= 5'd8) begin
          padded = (m_len + 32'd1) & ~32'd1;
          m_idx  = '0;
          if (!m_seen_first) begin
            m_first_size = m_len;
            m_seen_first = 1'b1;
          end
          m_skip = padded;
          if (m_tag == TagFmt) begin
            if (m_len < 32'd14) begin
              fail = 1'b1;
              code = ST_FMT_SHORT;
            end else begin
              foreach (fmt_cap[i]) fmt_cap[i] = '0;
              // size wrapped to an empty body: check the cleared capture
              if (padded == 32'd0) fail = fmt_fails(code);
              else m_phase = PH_FMT_BODY;
            end
          end else if (padded != 32'd0) begin
            m_phase = PH_SKIP_BODY;
          end
          if (m_phase == PH_CHUNK_HDR) begin
            m_tag = '0;
            m_len = '0;
          end
        end
      end
      PH_FMT_BODY: begin
        if (m_idx < CapLen) begin
          fmt_cap[m_idx] = b;
          m_idx++;
        end
        m_skip--;
        if (m_skip == 32'd0) begin
          fail    = fmt_fails(code);
          m_phase = PH_CHUNK_HDR;
          m_idx   = '0;
          m_tag   = '0;
          m_len   = '0;
        end
      end
      default: begin
        m_skip--;
        if (m_skip == 32'd0) begin
          m_phase = PH_CHUNK_HDR;
          m_idx   = '0;
          m_tag   = '0;
          m_len   = '0;
        end
      end
    endcase

    // end of file: ok only on a chunk boundary, an error found here wins
    if (!fail && last) begin
      fail = 1'b1;
      if (m_phase == PH_CHUNK_HDR && m_idx == 5'd0) code = ST_OK;
      else code = ST_TRUNCATED;
    end
    if (!fail) return;

    rep.pad                = '0;
    rep.first_chunk_length = m_first_size;
    rep.riff_length        = m_riff_size;
    rep.sample_bits        = m_bits;
    rep.frame_align        = cap16(12);
    rep.byte_rate          = cap32(8);
    rep.rate_hz            = cap32(4);
    rep.channel_count      = cap16(2);
    rep.fmt_code           = cap16(0);
    rep.status             = code;
    expected_reports.push_back(rep);

    if (last) clear_file();
    else m_dropping = 1'b1;
  endtask

  // file builders, little-endian
  function automatic void add8(input logic [7:0] b);
    file_bytes.push_back(b);
  endfunction

  function automatic void add16(input logic [15:0] v);
    add8(v[7:0]);
    add8(v[15:8]);
  endfunction

  function automatic void add32(input logic [31:0] v);
    add16(v[15:0]);
    add16(v[31:16]);
  endfunction

  function automatic void add_riff_head(input logic [31:0] size);
    add32(TagRiff);
    add32(size);
    add32(TagWave);
  endfunction

  // fmt chunk with its body cut or filled to the padded length
  function automatic void add_fmt_chunk(input logic [31:0] len, input logic [15:0] code,
                                        input logic [15:0] chans, input logic [31:0] rate,
                                        input logic [15:0] bits, input logic [15:0] extra);
    int body;
    body = int'((len + 32'd1) & ~32'd1);
    add32(TagFmt);
    add32(len);
    add16(code);
    add16(chans);
    add32(rate);
    add32($urandom);
    add16(16'($urandom));
    add16(bits);
    add16(extra);
    repeat (CapLen - body) void'(file_bytes.pop_back());
    repeat (body - CapLen) add8(8'($urandom));
  endfunction

  // mostly the configured value, sometimes anything
  function automatic logic [31:0] near(input logic [31:0] want);
    if ($urandom_range(99) < 85) return want;
    return $urandom;
  endfunction

  function automatic void add_random_chunk();
    logic [31:0] len;
    logic [31:0] tag;
    logic [15:0] code;
    logic [15:0] extra;
    int          body;
    if ($urandom_range(99) < 55) begin
      code  = ($urandom_range(99) < 65) ? FormatPcm : 16'($urandom);
      extra = '0;
      case ($urandom_range(9))
        0:       len = $urandom_range(13);
        1:       len = 32'hFFFF_FFFF;
        2:       len = $urandom_range(17, 14);
        3:       len = $urandom_range(48, 19);
        default: len = (code == FormatPcm) ? 32'd16 : 32'd18;
      endcase
      if (code != FormatPcm && $urandom_range(99) < 40) begin
        extra = 16'($urandom_range(8, 1));
        if ($urandom_range(1) == 1) len = 32'd18 + {16'd0, extra};
      end
      add_fmt_chunk(len, code, 16'(near(32'(want_channels))), near(want_rate),
                    16'(near(32'(want_bits))), extra);
    end else begin
      tag = ($urandom_range(99) < 70) ? TagData : $urandom;
      case ($urandom_range(19))
        0:       len = $urandom;
        1:       len = 32'hFFFF_FFFF;
        default: len = $urandom_range(11);
      endcase
      // huge sizes leave the file to end inside the body; all ones wraps to an empty body
      if (len == 32'hFFFF_FFFF) body = 0;
      else if (len > 32'd12) body = $urandom_range(6);
      else body = int'((len + 32'd1) & ~32'd1);
      add32(tag);
      add32(len);
      repeat (body) add8(8'($urandom));
    end
  endfunction

  // hand the first keep bytes of the built file to the driver
  function automatic void emit_file(input int keep);
    file_byte_t item;
    for (int i = 0; i < keep; i++) begin
      item.data = file_bytes[i];
      item.last = (i == keep - 1);
      pending_bytes.push_back(item);
    end
    bytes_queued += keep;
    files_queued++;
    file_bytes.delete();
  endfunction

  function automatic void gen_wave_file();
    int shape;
    int keep;
    shape = $urandom_range(99);
    if (shape < 6) begin
      repeat ($urandom_range(30, 1)) add8(8'($urandom));
    end else begin
      add32(($urandom_range(99) < 4) ? (TagRiff ^ (32'd1 << $urandom_range(31))) : TagRiff);
      add32($urandom);
      add32(($urandom_range(99) < 4) ? (TagWave ^ (32'd1 << $urandom_range(31))) : TagWave);
      repeat ($urandom_range(3)) add_random_chunk();
    end
    keep = file_bytes.size();
    if (shape >= 6 && $urandom_range(99) < 12) keep = $urandom_range(keep, 1);
    emit_file(keep);
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_CHANNELS: want_channels = val[15:0];
      REG_RATE:     want_rate     = val;
      REG_BITS:     want_bits     = val[15:0];
      default:      ;
    endcase
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // byte driver: holds an item until taken, idles at random
  always @(posedge clk_i) begin : drive_bytes
    file_byte_t nxt;
    logic       give;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      give = (pending_bytes.size() != 0) && ($urandom_range(99) >= send_idle_pct);
      if (give) begin
        nxt = pending_bytes.pop_front();
      end else begin
        nxt.data = 8'($urandom);
        nxt.last = 1'($urandom);
      end
      s_axis_tdata  <= nxt.data;
      s_axis_tlast  <= nxt.last;
      s_axis_tvalid <= give;
    end
  end

  // predicts on accepted bytes, checks accepted reports, watches for a hang
  always @(posedge clk_i) begin : watch_ports
    status_report_t got_report;
    status_report_t want_report;
    logic           moved;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      quiet_cycles  <= 0;
    end else begin
      moved = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
              (cfg_valid_i && cfg_ready_o);
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got_report = m_axis_tdata;
        if (expected_reports.size() == 0) begin
          $display("%0t ns: unexpected report: expected none, got %0h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want_report = expected_reports.pop_front();
          check_field("status", 32'(want_report.status), 32'(got_report.status));
          check_field("fmt_code", 32'(want_report.fmt_code), 32'(got_report.fmt_code));
          check_field("channel_count", 32'(want_report.channel_count),
                      32'(got_report.channel_count));
          check_field("rate_hz", want_report.rate_hz, got_report.rate_hz);
          check_field("byte_rate", want_report.byte_rate, got_report.byte_rate);
          check_field("frame_align", 32'(want_report.frame_align),
                      32'(got_report.frame_align));
          check_field("sample_bits", 32'(want_report.sample_bits),
                      32'(got_report.sample_bits));
          check_field("riff_length", want_report.riff_length, got_report.riff_length);
          check_field("first_chunk_length", want_report.first_chunk_length,
                      got_report.first_chunk_length);
          check_field("pad", 32'(want_report.pad), 32'(got_report.pad));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (moved) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("%0t ns: watchdog, no handshake for %0d cycles", $time, WatchdogLimit);
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : run_test
    int phase_bytes;
    int phase_files;
    clear_file();
    want_channels = 16'd1;
    want_rate     = 32'd44100;
    want_bits     = 16'd16;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 5; p++) begin
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase

      // block is idle here; upper halves of 16-bit writes must be ignored
      case (p)
        1: begin
          write_reg(REG_CHANNELS, {16'($urandom), 16'hFFFF});
          write_reg(REG_RATE, 32'hFFFF_FFFF);
          write_reg(REG_BITS, {16'($urandom), 16'hFFFF});
        end
        2: begin
          write_reg(REG_CHANNELS, 32'd0);
          write_reg(REG_RATE, 32'd0);
          write_reg(REG_BITS, 32'd0);
        end
        3: begin
          write_reg(REG_SPARE, $urandom);
          write_reg(REG_CHANNELS, $urandom_range(8, 1));
          write_reg(REG_RATE, $urandom);
          write_reg(REG_BITS, $urandom_range(32, 1));
        end
        4: begin
          write_reg(REG_CHANNELS, 32'd1);
          write_reg(REG_RATE, 32'd44100);
          write_reg(REG_BITS, 32'd16);
        end
        default: ;
      endcase

      @(negedge clk_i);
      if (p == 0) begin
        // header alone ends on a chunk boundary
        add_riff_head(32'd4);
        emit_file(file_bytes.size());
        // cut inside the header
        add_riff_head(32'd4);
        emit_file(7);
        // wrong id, trailing bytes dropped up to the mark
        add32(32'h5846_4952);
        add32(32'hFFFF_FFFF);
        add32(TagWave);
        add16(16'hA5A5);
        emit_file(file_bytes.size());
        // wrong form type on the final byte
        add32(TagRiff);
        add32(32'h0);
        add32(~TagWave);
        emit_file(file_bytes.size());
        // fmt size below 14
        add_riff_head(32'd40);
        add_fmt_chunk(32'd13, FormatPcm, 16'd1, 32'd44100, 16'd16, 16'd0);
        emit_file(file_bytes.size());
        // fmt size wraps to an empty body
        add_riff_head(32'd20);
        add_fmt_chunk(32'hFFFF_FFFF, FormatPcm, 16'd1, 32'd44100, 16'd16, 16'd0);
        emit_file(file_bytes.size());
        // PCM body too short
        add_riff_head(32'd26);
        add_fmt_chunk(32'd14, FormatPcm, 16'd1, 32'd44100, 16'd16, 16'd0);
        emit_file(file_bytes.size());
        // extra bytes missing, found on the final byte
        add_riff_head(32'd30);
        add_fmt_chunk(32'd18, 16'hFFFE, 16'd1, 32'd44100, 16'd16, 16'd22);
        emit_file(file_bytes.size());
        // good PCM file, odd data chunk padded
        add_riff_head(32'd44);
        add_fmt_chunk(32'd16, FormatPcm, 16'd1, 32'd44100, 16'd16, 16'd0);
        add32(TagData);
        add32(32'd3);
        add32($urandom);
        emit_file(file_bytes.size());
        // channels, rate and bits mismatches
        add_riff_head(32'd36);
        add_fmt_chunk(32'd16, FormatPcm, 16'd2, 32'd44100, 16'd16, 16'd0);
        add32(TagData);
        emit_file(file_bytes.size());
        add_riff_head(32'd36);
        add_fmt_chunk(32'd16, FormatPcm, 16'd1, 32'd48000, 16'd16, 16'd0);
        emit_file(file_bytes.size());
        add_riff_head(32'd36);
        add_fmt_chunk(32'd16, FormatPcm, 16'd1, 32'd44100, 16'd24, 16'd0);
        emit_file(file_bytes.size());
        // extensible with enough extra, odd size, then a cut data body
        add_riff_head(32'd48);
        add_fmt_chunk(32'd19, 16'hFFFE, 16'd1, 32'd44100, 16'd16, 16'd1);
        add32(TagData);
        add32(32'd8);
        add16(16'h0);
        emit_file(file_bytes.size());
      end

      phase_bytes = bytes_queued;
      phase_files = files_queued;
      while (bytes_queued - phase_bytes < 70 || files_queued - phase_files < 2)
        gen_wave_file();

      // drain: all bytes taken, all reports seen, then the pipeline tail
      @(negedge clk_i);
      while (pending_bytes.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
        @(negedge clk_i);
      repeat (DrainCycles) @(negedge clk_i);
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
